>>> rtl/bbp_pkg.sv
// ----------------------------------------------------------------------------
// bbp_pkg: shared types and constants of the bimodal branch predictor
// Transfer payloads, table entry and statistics layouts, opcodes, counter limits
// and a saturating increment.
package bbp_pkg;

  localparam int unsigned TableEntriesDef = 64;

  localparam logic [6:0]  OPC_BRANCH = 7'h63;
  localparam logic [6:0]  OPC_JAL    = 7'h6F;

  localparam logic [1:0]  CNT_INIT      = 2'd1;
  localparam logic [1:0]  CNT_MIN       = 2'd0;
  localparam logic [1:0]  CNT_MAX       = 2'd3;
  localparam logic [1:0]  CNT_TAKEN_MIN = 2'd2;

  localparam logic [63:0] PC_STEP  = 64'd4;
  localparam logic [31:0] STAT_MAX = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_QUERY  = 1'b0,
    OP_UPDATE = 1'b1
  } bbp_op_e;

  typedef struct packed {
    bbp_op_e     operation;
    logic [63:0] pc;
    logic [31:0] instruction;
    logic        taken;
    logic [63:0] actual_target;
  } bbp_in_t;

  typedef struct packed {
    logic        valid_res;
    logic        btb_hit;
    logic        pred_taken;
    logic [63:0] pred_target;
    logic        update_correct;
    logic [31:0] prediction_count;
    logic [31:0] correct_count;
    logic [31:0] mispredict_count;
  } bbp_out_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [1:0]  counter;
    logic [63:0] target;
  } bbp_entry_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] correct;
    logic [31:0] wrong;
  } bbp_stats_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == STAT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

>>> rtl/bbp_table.sv
// ----------------------------------------------------------------------------
// bbp_table: predictor table memory
// Single-port-write, single-read synchronous memory with a registered read,
// write-to-read forwarding and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module bbp_table #(
  parameter int unsigned TABLE_ENTRIES = bbp_pkg::TableEntriesDef,
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output bbp_pkg::bbp_entry_t rd_entry_o,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  bbp_pkg::bbp_entry_t wr_entry_i,
  output logic                init_done_o
);

  bbp_pkg::bbp_entry_t mem [TABLE_ENTRIES];
  bbp_pkg::bbp_entry_t rd_q;

  logic            clr_busy_q, clr_busy_d;
  logic [IdxW-1:0] clr_idx_q, clr_idx_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + IdxW'(1);
      if (clr_idx_q == IdxW'(TABLE_ENTRIES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
  end

  // forward a same-edge write to the read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
        rd_q <= wr_entry_i;
      end else begin
        rd_q <= mem[rd_idx_i];
      end
    end
  end

  assign rd_entry_o  = rd_q;
  assign init_done_o = !clr_busy_q;

endmodule

>>> rtl/bbp_eval.sv
// ----------------------------------------------------------------------------
// bbp_eval: prediction, scoring and training logic
// Decodes the instruction, forms the prediction from the read entry, scores
// updates, trains the entry and steps the statistics.
// ----------------------------------------------------------------------------
module bbp_eval (
  input  bbp_pkg::bbp_in_t    item_i,
  input  bbp_pkg::bbp_entry_t entry_i,
  input  bbp_pkg::bbp_stats_t stats_i,
  output bbp_pkg::bbp_out_t   result_o,
  output bbp_pkg::bbp_stats_t stats_o,
  output logic                wr_en_o,
  output bbp_pkg::bbp_entry_t wr_entry_o
);

  logic [6:0]  opc;
  logic        is_br, is_jal, valid;
  logic        hit, ptaken, corr;
  logic [63:0] ptarget, jal_imm, jal_tgt;
  bbp_pkg::bbp_entry_t base;

  always_comb begin
    opc     = item_i.instruction[6:0];
    is_br   = (opc == bbp_pkg::OPC_BRANCH);
    is_jal  = (opc == bbp_pkg::OPC_JAL);
    valid   = is_br || is_jal;

    hit     = entry_i.valid && (entry_i.tag == item_i.pc);
    ptaken  = hit && (entry_i.counter >= bbp_pkg::CNT_TAKEN_MIN);
    ptarget = ptaken ? entry_i.target : item_i.pc + bbp_pkg::PC_STEP;

    jal_imm = {{43{item_i.instruction[31]}}, item_i.instruction[31],
               item_i.instruction[19:12], item_i.instruction[20],
               item_i.instruction[30:21], 1'b0};
    jal_tgt = item_i.pc + jal_imm;

    result_o           = '0;
    result_o.valid_res = valid;
    stats_o            = stats_i;
    corr               = 1'b0;
    wr_en_o            = 1'b0;

    if (item_i.operation == bbp_pkg::OP_QUERY) begin
      if (is_br) begin
        stats_o.total        = bbp_pkg::sat_inc(stats_i.total);
        result_o.btb_hit     = hit;
        result_o.pred_taken  = ptaken;
        result_o.pred_target = ptarget;
      end else if (is_jal) begin
        stats_o.total        = bbp_pkg::sat_inc(stats_i.total);
        result_o.pred_taken  = 1'b1;
        result_o.pred_target = jal_tgt;
      end
    end else if (valid) begin
      if (is_br) begin
        corr = (ptaken == item_i.taken) && (!ptaken || (ptarget == item_i.actual_target));
      end else begin
        corr = item_i.taken && (jal_tgt == item_i.actual_target);
      end
      if (corr) begin
        stats_o.correct = bbp_pkg::sat_inc(stats_i.correct);
      end else begin
        stats_o.wrong = bbp_pkg::sat_inc(stats_i.wrong);
      end
      wr_en_o = is_br;
    end
    result_o.update_correct   = corr;
    result_o.prediction_count = stats_o.total;
    result_o.correct_count    = stats_o.correct;
    result_o.mispredict_count = stats_o.wrong;

    // allocate on miss, then step the counter
    if (hit) begin
      base = entry_i;
    end else begin
      base.valid   = 1'b1;
      base.tag     = item_i.pc;
      base.counter = bbp_pkg::CNT_INIT;
      base.target  = item_i.actual_target;
    end
    wr_entry_o = base;
    if (item_i.taken) begin
      if (base.counter != bbp_pkg::CNT_MAX) begin
        wr_entry_o.counter = base.counter + 2'd1;
      end
      wr_entry_o.target = item_i.actual_target;
    end else if (base.counter != bbp_pkg::CNT_MIN) begin
      wr_entry_o.counter = base.counter - 2'd1;
    end
  end

endmodule

>>> rtl/bimodal_branch_predictor_btb.sv
// ----------------------------------------------------------------------------
// bimodal_branch_predictor_btb: bimodal branch predictor with target buffer
// Direct-mapped table of 2-bit counters, tags and targets for RISC-V
// conditional branches and JAL, with saturating prediction statistics.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while in_stall_o is low; it waits in the first
// stage register, then its result moves to the output register. The table is a
// synchronous memory read on accept and written back as the item leaves the
// first stage; a write meeting a read of the same entry is forwarded into the
// read data. The table index is pc bits [log2(TABLE_ENTRIES)+1:2], so the user
// must make TABLE_ENTRIES a power of two; the block does not enforce it. After
// reset the table is cleared one entry per cycle, while in_stall_o stays high.
// ----------------------------------------------------------------------------
module bimodal_branch_predictor_btb #(
  parameter int unsigned TABLE_ENTRIES = bbp_pkg::TableEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbp_pkg::bbp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bbp_pkg::bbp_out_t out_data_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic                init_done, accept, s1_adv;
  logic                s1_valid_q, s1_valid_d;
  logic                out_valid_q, out_valid_d;
  bbp_pkg::bbp_in_t    s1_q;
  bbp_pkg::bbp_out_t   out_q, result;
  bbp_pkg::bbp_stats_t stats_q, stats_next;
  bbp_pkg::bbp_entry_t rd_entry, wr_entry;
  logic                wr_en;
  logic [IdxW-1:0]     rd_idx, wr_idx;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = !init_done || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_idx     = in_data_i.pc[IdxW+1:2];
  assign wr_idx     = s1_q.pc[IdxW+1:2];

  bbp_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_en_i    (s1_valid_q && s1_adv && wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry),
    .init_done_o(init_done)
  );

  bbp_eval u_eval (
    .item_i    (s1_q),
    .entry_i   (rd_entry),
    .stats_i   (stats_q),
    .result_o  (result),
    .stats_o   (stats_next),
    .wr_en_o   (wr_en),
    .wr_entry_o(wr_entry)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      s1_valid_d  = 1'b0;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      stats_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_valid_q && s1_adv) begin
        stats_q <= stats_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
    if (s1_valid_q && s1_adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
